>>> rtl/nsfc_pkg.sv
// shared types, character codes and the hex digit decoder for the nmea sentence framer
// no dependencies

package nsfc_pkg;

    localparam int MAX_LEN_DEF = 128;

    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2A;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_VERDICT = 2'd1,
        KIND_DROP    = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_BODY = 4'b0010,
        PH_HI   = 4'b0100,
        PH_LO   = 4'b1000
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  byte_value;
        logic [6:0]  position;
        logic        checksum_ok;
        logic [7:0]  sentence_length;
        logic [7:0]  computed_sum;
        logic [7:0]  received_sum;
    } result_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = 4'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = 4'(c - 8'h41 + 8'd10);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = 4'(c - 8'h61 + 8'd10);
        end
        return v;
    endfunction

endpackage

>>> rtl/nsfc_in_stage.sv
// input register for received characters, valid/stall handshake on the upstream side
// depends on nothing outside this file

module nsfc_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_in,
    input  logic       go,
    output logic       held_valid,
    output logic [7:0] held_char
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] char_reg;
    logic       take;

    assign in_stall   = valid_reg && !go;
    assign take       = in_valid && !in_stall;
    assign held_valid = valid_reg;
    assign held_char  = char_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (go)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            char_reg <= char_in;
        end
    end

endmodule

>>> rtl/nsfc_step.sv
// framing state, running xor and verdict logic for one character per cycle while go is high
// depends on nsfc_pkg

module nsfc_step #(
    parameter int MAX_LEN = nsfc_pkg::MAX_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [7:0]        ch,
    output logic              has_result,
    output nsfc_pkg::result_t res
);

    localparam logic [7:0] FILL_LIMIT = 8'(MAX_LEN - 1);
    localparam logic [7:0] FILL_MAX   = 8'(MAX_LEN);

    nsfc_pkg::phase_t phase_reg;
    nsfc_pkg::phase_t phase_next;
    logic [7:0]       fill_reg;
    logic [7:0]       fill_next;
    logic [7:0]       xor_reg;
    logic [7:0]       xor_next;
    logic [3:0]       hi_reg;
    logic [3:0]       hi_next;

    always_comb
    begin
        logic [7:0] recv;
        recv       = {hi_reg, nsfc_pkg::hex_value(ch)};
        phase_next = phase_reg;
        fill_next  = fill_reg;
        xor_next   = xor_reg;
        hi_next    = hi_reg;
        has_result = 1'b0;
        res        = '0;
        res.kind   = nsfc_pkg::KIND_BYTE;
        if (ch == nsfc_pkg::CH_START)
        begin
            phase_next     = nsfc_pkg::PH_BODY;
            fill_next      = 8'd1;
            xor_next       = 8'd0;
            has_result     = 1'b1;
            res.byte_value = ch;
        end
        else
        begin
            case (phase_reg)
                nsfc_pkg::PH_BODY:
                begin
                    has_result = 1'b1;
                    if (ch == nsfc_pkg::CH_STAR)
                    begin
                        phase_next     = nsfc_pkg::PH_HI;
                        fill_next      = fill_reg + 8'd1;
                        res.byte_value = ch;
                        res.position   = fill_reg[6:0];
                    end
                    else if (fill_reg >= FILL_LIMIT)
                    begin
                        phase_next = nsfc_pkg::PH_IDLE;
                        fill_next  = 8'd0;
                        res.kind   = nsfc_pkg::KIND_DROP;
                    end
                    else
                    begin
                        fill_next      = fill_reg + 8'd1;
                        xor_next       = xor_reg ^ ch;
                        res.byte_value = ch;
                        res.position   = fill_reg[6:0];
                    end
                end
                nsfc_pkg::PH_HI:
                begin
                    hi_next    = nsfc_pkg::hex_value(ch);
                    phase_next = nsfc_pkg::PH_LO;
                end
                nsfc_pkg::PH_LO:
                begin
                    has_result          = 1'b1;
                    res.kind            = nsfc_pkg::KIND_VERDICT;
                    res.checksum_ok     = (recv == xor_reg);
                    res.sentence_length = fill_reg;
                    res.computed_sum    = xor_reg;
                    res.received_sum    = recv;
                    phase_next          = nsfc_pkg::PH_IDLE;
                    fill_next           = 8'd0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= nsfc_pkg::PH_IDLE;
            fill_reg  <= 8'd0;
            xor_reg   <= 8'd0;
            hi_reg    <= 4'd0;
        end
        else if (go)
        begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            xor_reg   <= xor_next;
            hi_reg    <= hi_next;
        end
    end

    // fill never passes the sentence limit
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= FILL_MAX)
        else $error("fill count beyond limit");

    // outside a sentence nothing is held
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == nsfc_pkg::PH_IDLE |-> fill_reg == 8'd0)
        else $error("idle with non-zero fill");

    // a start character always reopens the sentence
    assert property (@(posedge clk) disable iff (!rst_n)
        go && ch == nsfc_pkg::CH_START |=> phase_reg == nsfc_pkg::PH_BODY && fill_reg == 8'd1)
        else $error("start character did not restart");

    // a verdict covers at least the start and star characters
    assert property (@(posedge clk) disable iff (!rst_n)
        go && has_result && res.kind == nsfc_pkg::KIND_VERDICT |-> res.sentence_length >= 8'd2)
        else $error("verdict length too short");

endmodule

>>> rtl/nsfc_out_reg.sv
// result register driving the downstream valid/stall handshake
// depends on nsfc_pkg

module nsfc_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic              has_result,
    input  nsfc_pkg::result_t res_in,
    input  logic              out_stall,
    output logic              out_valid,
    output logic              out_free,
    output nsfc_pkg::result_t res_out
);

    logic              valid_reg;
    logic              valid_next;
    nsfc_pkg::result_t res_reg;

    assign out_free  = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign res_out   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (go)
        begin
            valid_next = has_result;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && has_result)
        begin
            res_reg <= res_in;
        end
    end

endmodule

>>> rtl/nmea_sentence_framer_checker_core.sv
// top level of the nmea sentence framer and checksum checker
// depends on nsfc_pkg, nsfc_in_stage, nsfc_step, nsfc_out_reg
//
// input channel: one received character per word on char_in, in_valid/in_stall
// output channel: one word per tagged sentence byte, verdict or drop marker,
//   out_valid/out_stall, fields kind, byte_value, position, checksum_ok,
//   sentence_length, computed_sum, received_sum (unused fields read as zero)
// a character is registered in the input register on acceptance and processed once
//   the result register is free, which then registers its result for the output
// throughput is one character per cycle while out_stall stays low; the single state update per character
//   sits between the input register and the result register
// characters outside a sentence and the first checksum digit give no word
// reset clears the framing state to awaiting '$' and empties both registers
// while out_stall holds a result, one more character may wait in the input
//   register; in_stall rises only when that register is full and cannot drain

module nmea_sentence_framer_checker_core #(
    parameter int MAX_LEN = nsfc_pkg::MAX_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] byte_value,
    output logic [6:0] position,
    output logic       checksum_ok,
    output logic [7:0] sentence_length,
    output logic [7:0] computed_sum,
    output logic [7:0] received_sum
);

    logic              held_valid;
    logic [7:0]        held_char;
    logic              out_free;
    logic              go;
    logic              has_result;
    nsfc_pkg::result_t step_res;
    nsfc_pkg::result_t res_out;

    assign go = held_valid && out_free;

    nsfc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_in    (char_in),
        .go         (go),
        .held_valid (held_valid),
        .held_char  (held_char)
    );

    nsfc_step #(
        .MAX_LEN (MAX_LEN)
    ) u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .ch         (held_char),
        .has_result (has_result),
        .res        (step_res)
    );

    nsfc_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .has_result (has_result),
        .res_in     (step_res),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_free   (out_free),
        .res_out    (res_out)
    );

    assign kind            = res_out.kind;
    assign byte_value      = res_out.byte_value;
    assign position        = res_out.position;
    assign checksum_ok     = res_out.checksum_ok;
    assign sentence_length = res_out.sentence_length;
    assign computed_sum    = res_out.computed_sum;
    assign received_sum    = res_out.received_sum;

endmodule

>>> sim/tb.sv
// self-checking bench for nmea_sentence_framer_checker_core: framing, restarts, overflow, checksums
// clocked driver and monitor around a predictor of the framing state
// depends on nsfc_pkg and the core rtl
`timescale 1ns / 100ps

module tb;

    localparam int MAX_LEN    = nsfc_pkg::MAX_LEN_DEF;
    localparam int HOLD_LEN   = 300;
    localparam int LIMIT      = 400000;
    localparam int PHASE_ITEMS = 385;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] char_in = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [6:0] position;
    logic       checksum_ok;
    logic [7:0] sentence_length;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;

    logic [7:0]        pending_chars[$];
    nsfc_pkg::result_t expected_words[$];

    nsfc_pkg::phase_t frame_phase = nsfc_pkg::PH_IDLE;
    logic [7:0]       fill_cnt = 8'd0;
    logic [7:0]       run_xor = 8'd0;
    logic [3:0]       hi_nib = 4'd0;

    int idle_pct = 0;
    int stall_pct = 0;
    bit hold_go = 1'b0;
    bit hold_done = 1'b0;
    int hold_count = 0;

    int err_count = 0;
    int cycle_count = 0;
    int chars_taken = 0;
    int items_queued = 0;
    int bytes_seen = 0;
    int good_verdicts = 0;
    int bad_verdicts = 0;
    int drops_seen = 0;

    nmea_sentence_framer_checker_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .char_in         (char_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .byte_value      (byte_value),
        .position        (position),
        .checksum_ok     (checksum_ok),
        .sentence_length (sentence_length),
        .computed_sum    (computed_sum),
        .received_sum    (received_sum)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return c[3:0];
        end
        if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
        begin
            return c[3:0] + 4'd9;
        end
        return 4'd0;
    endfunction

    task automatic frame_char(input logic [7:0] c);
        nsfc_pkg::result_t r;
        bit                emit;
        logic [7:0]        recv;
        r = '0;
        emit = 1'b0;
        if (c == nsfc_pkg::CH_START)
        begin
            frame_phase = nsfc_pkg::PH_BODY;
            fill_cnt = 8'd1;
            run_xor = 8'd0;
            r.kind = nsfc_pkg::KIND_BYTE;
            r.byte_value = c;
            emit = 1'b1;
        end
        else
        begin
            case (frame_phase)
                nsfc_pkg::PH_BODY:
                begin
                    emit = 1'b1;
                    if (c == nsfc_pkg::CH_STAR)
                    begin
                        r.kind = nsfc_pkg::KIND_BYTE;
                        r.byte_value = c;
                        r.position = fill_cnt[6:0];
                        fill_cnt = fill_cnt + 8'd1;
                        frame_phase = nsfc_pkg::PH_HI;
                    end
                    else if (fill_cnt >= MAX_LEN - 1)
                    begin
                        r.kind = nsfc_pkg::KIND_DROP;
                        fill_cnt = 8'd0;
                        frame_phase = nsfc_pkg::PH_IDLE;
                    end
                    else
                    begin
                        r.kind = nsfc_pkg::KIND_BYTE;
                        r.byte_value = c;
                        r.position = fill_cnt[6:0];
                        fill_cnt = fill_cnt + 8'd1;
                        run_xor = run_xor ^ c;
                    end
                end
                nsfc_pkg::PH_HI:
                begin
                    hi_nib = digit_value(c);
                    frame_phase = nsfc_pkg::PH_LO;
                end
                nsfc_pkg::PH_LO:
                begin
                    recv = {hi_nib, digit_value(c)};
                    r.kind = nsfc_pkg::KIND_VERDICT;
                    r.checksum_ok = (recv == run_xor);
                    r.sentence_length = fill_cnt;
                    r.computed_sum = run_xor;
                    r.received_sum = recv;
                    emit = 1'b1;
                    frame_phase = nsfc_pkg::PH_IDLE;
                    fill_cnt = 8'd0;
                end
                default:
                begin
                end
            endcase
        end
        if (emit)
        begin
            expected_words.push_back(r);
        end
    endtask

    // sender: a word is taken at an edge with valid high and stall low
    always @(posedge clk)
    begin
        bit busy;
        if (rst_n)
        begin
            busy = in_valid;
            if (in_valid && !in_stall)
            begin
                frame_char(char_in);
                chars_taken++;
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (pending_chars.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    char_in <= pending_chars.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall, with a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            out_stall <= 1'b1;
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_LEN - 1)
            begin
                hold_done <= 1'b1;
            end
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
            if (!hold_go)
            begin
                hold_done <= 1'b0;
                hold_count <= 0;
            end
        end
    end

    function automatic void check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, got_v);
            err_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        nsfc_pkg::result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected output word: kind %0h byte %0h", kind, byte_value);
                err_count++;
            end
            else
            begin
                e = expected_words.pop_front();
                check_field("kind", e.kind, kind);
                check_field("byte_value", e.byte_value, byte_value);
                check_field("position", e.position, position);
                check_field("checksum_ok", e.checksum_ok, checksum_ok);
                check_field("sentence_length", e.sentence_length, sentence_length);
                check_field("computed_sum", e.computed_sum, computed_sum);
                check_field("received_sum", e.received_sum, received_sum);
                case (e.kind)
                    nsfc_pkg::KIND_BYTE:    bytes_seen++;
                    nsfc_pkg::KIND_VERDICT: if (e.checksum_ok) good_verdicts++; else bad_verdicts++;
                    default:                drops_seen++;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic offer(input logic [7:0] c);
        pending_chars.push_back(c);
        items_queued++;
    endtask

    task automatic offer_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            offer(s[i]);
        end
    endtask

    function automatic logic [7:0] body_byte();
        logic [7:0] c;
        c = ($urandom_range(1) == 0) ? 8'($urandom_range(32, 126)) : 8'($urandom_range(255));
        while (c == nsfc_pkg::CH_START || c == nsfc_pkg::CH_STAR)
        begin
            c = 8'($urandom_range(255));
        end
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
        if (nib < 4'd10)
        begin
            return "0" + nib;
        end
        return (lower ? "a" : "A") + nib - 8'd10;
    endfunction

    task automatic queue_sentence(input int body_len, input bit sum_good, input bit lower);
        int         i;
        logic [7:0] xs;
        logic [7:0] ch;
        logic [7:0] sent;
        xs = 8'd0;
        offer(nsfc_pkg::CH_START);
        for (i = 0; i < body_len; i++)
        begin
            ch = body_byte();
            xs = xs ^ ch;
            offer(ch);
        end
        offer(nsfc_pkg::CH_STAR);
        sent = xs;
        if (!sum_good)
        begin
            sent = 8'($urandom_range(255));
            if (sent == xs)
            begin
                sent = ~xs;
            end
        end
        offer(hex_char(sent[7:4], lower));
        offer(hex_char(sent[3:0], lower));
    endtask

    // broken framing: restarts in the body, in the digits, and digits that are not hex
    task automatic queue_broken();
        int i;
        int n;
        n = $urandom_range(0, 6);
        offer(nsfc_pkg::CH_START);
        for (i = 0; i < n; i++)
        begin
            offer(body_byte());
        end
        case ($urandom_range(3))
            0: offer(nsfc_pkg::CH_START);
            1:
            begin
                offer(nsfc_pkg::CH_STAR);
                offer(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
                offer(nsfc_pkg::CH_START);
            end
            2:
            begin
                offer(nsfc_pkg::CH_STAR);
                offer(body_byte());
                offer(body_byte());
            end
            default:
            begin
                offer(nsfc_pkg::CH_STAR);
                offer(nsfc_pkg::CH_START);
            end
        endcase
    endtask

    task automatic queue_random(input int n_items);
        int start;
        int r;
        int i;
        int n;
        int len;
        start = items_queued;
        while (items_queued - start < n_items)
        begin
            r = $urandom_range(99);
            if (r < 70)
            begin
                if ($urandom_range(29) == 0)
                begin
                    len = $urandom_range(MAX_LEN - 6, MAX_LEN + 2);
                end
                else
                begin
                    len = $urandom_range(0, 24);
                end
                queue_sentence(len, $urandom_range(3) != 0, 1'($urandom_range(1)));
            end
            else if (r < 85)
            begin
                n = $urandom_range(1, 5);
                for (i = 0; i < n; i++)
                begin
                    offer(body_byte());
                end
            end
            else
            begin
                queue_broken();
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_chars.size() != 0 || in_valid || expected_words.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        offer(8'h00);
        offer(8'hFF);
        offer_text("*5$*00$");
        offer(8'hFF);
        offer(8'h00);
        offer_text("*fF$A$*Gz$*1$*01");
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        queue_sentence(60, 1'b1, 1'b0);
        queue_sentence(MAX_LEN - 2, 1'b1, 1'b1);
        queue_sentence(MAX_LEN - 1, 1'b1, 1'b0);
        @(negedge clk);
        hold_go = 1'b1;
        while (!hold_done)
        begin
            @(negedge clk);
        end
        hold_go = 1'b0;
        wait_drained();

        idle_pct = 0;
        stall_pct = 0;
        queue_random(PHASE_ITEMS);
        wait_drained();

        idle_pct = 53;
        stall_pct = 0;
        queue_random(PHASE_ITEMS);
        wait_drained();

        idle_pct = 0;
        stall_pct = 53;
        queue_random(PHASE_ITEMS);
        wait_drained();

        idle_pct = 37;
        stall_pct = 37;
        queue_random(PHASE_ITEMS);
        wait_drained();

        repeat (8) @(negedge clk);
        if (expected_words.size() != 0)
        begin
            $error("%0d expected words never arrived", expected_words.size());
            err_count++;
        end
        $display("%0d characters taken over %0d cycles, with idle and stall phases",
                 chars_taken, cycle_count);
        $display("%0d sentence bytes, %0d good and %0d bad verdicts, %0d overflow drops",
                 bytes_seen, good_verdicts, bad_verdicts, drops_seen);
        if (err_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> nmea_sentence_framer_checker_core.f
rtl/nsfc_pkg.sv
rtl/nsfc_in_stage.sv
rtl/nsfc_step.sv
rtl/nsfc_out_reg.sv
rtl/nmea_sentence_framer_checker_core.sv
sim/tb.sv
